// ===== rtl/core/p4argb_pkg.sv =====
// shared types, constants and helpers for the planar group to argb converter
package p4argb_pkg;

    localparam int GROUP_PIXELS = 16;
    localparam int NUM_PLANES   = 4;
    localparam int PLANE_W      = 16;
    localparam int ENTRY_W      = 12;
    localparam int NUM_ENTRIES  = 16;
    localparam int PAL_REGS     = 4;
    localparam int REG_W        = 48;
    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 5;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_PAL_0_3   = 2'd0,
        REG_PAL_4_7   = 2'd1,
        REG_PAL_8_11  = 2'd2,
        REG_PAL_12_15 = 2'd3
    } t_reg_idx;

    typedef logic [NUM_ENTRIES-1:0][ENTRY_W-1:0] t_palette;
    typedef logic [GROUP_PIXELS-1:0][31:0]       t_pix_arr;

    // 3-bit channel to 8 bits by bit replication
    function automatic logic [7:0] widen3(input logic [2:0] v);
        return {v, v, v[2:1]};
    endfunction

endpackage

// ===== rtl/core/p4argb_regs.sv =====
// apb palette registers
module p4argb_regs
    import p4argb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_palette              o_palette
);

    logic [PAL_REGS-1:0][REG_W-1:0] r_pal;
    t_reg_idx                       w_idx;
    logic                           w_wr;

    assign pready = 1'b1;
    // register select from the 8-byte aligned address, low bits ignored
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:3]);
    assign w_wr   = psel && penable && pwrite && paddr[2:0] == paddr[2:0];

    // palette storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PAL_0_3:   r_pal[0] <= pwdata[REG_W-1:0];
                REG_PAL_4_7:   r_pal[1] <= pwdata[REG_W-1:0];
                REG_PAL_8_11:  r_pal[2] <= pwdata[REG_W-1:0];
                REG_PAL_12_15: r_pal[3] <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_PAL_0_3:   prdata = APB_DATA_W'(r_pal[0]);
            REG_PAL_4_7:   prdata = APB_DATA_W'(r_pal[1]);
            REG_PAL_8_11:  prdata = APB_DATA_W'(r_pal[2]);
            REG_PAL_12_15: prdata = APB_DATA_W'(r_pal[3]);
            default:       prdata = '0;
        endcase
    end

    assign o_palette = t_palette'(r_pal);

endmodule

// ===== rtl/core/p4argb_lane.sv =====
// one pixel lane: palette lookup and channel widening
module p4argb_lane
    import p4argb_pkg::*;
(
    input  logic [3:0]  i_index,
    input  t_palette    i_palette,
    output logic [31:0] o_argb
);

    logic [ENTRY_W-1:0] w_entry;

    assign w_entry = i_palette[i_index];

    // fourth bit of each nibble is dropped
    assign o_argb = {ALPHA_OPAQUE,
                     widen3(w_entry[10:8]),
                     widen3(w_entry[6:4]),
                     widen3(w_entry[2:0])};

endmodule

// ===== rtl/core/p4argb_serial.sv =====
// group bank and pixel serialiser, one pixel per cycle while i_ready is high
module p4argb_serial
    import p4argb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_pix_arr    i_lanes,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pixel_argb,
    output logic        o_last_pixel
);

    localparam int CNT_W = $clog2(GROUP_PIXELS);

    t_pix_arr         r_bank, n_bank;
    logic             r_bank_full, n_bank_full;
    t_pix_arr         r_sh, n_sh;
    logic             r_sh_valid, n_sh_valid;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_last, w_out_fire, w_in_fire, w_load;

    assign w_last     = r_cnt == CNT_W'(GROUP_PIXELS - 1);
    assign w_out_fire = r_sh_valid && i_ready;
    // bank moves to the shifter when it is empty or its last pixel leaves
    assign w_load     = r_bank_full && (!r_sh_valid || (w_out_fire && w_last));
    assign o_ready    = !r_bank_full || w_load;
    assign w_in_fire  = i_valid && o_ready;

    // next state
    always_comb begin
        n_bank      = r_bank;
        n_bank_full = r_bank_full;
        n_sh        = r_sh;
        n_sh_valid  = r_sh_valid;
        n_cnt       = r_cnt;
        if (w_load) begin
            n_bank_full = 1'b0;
        end
        if (w_in_fire) begin
            n_bank      = i_lanes;
            n_bank_full = 1'b1;
        end
        if (w_load) begin
            n_sh       = r_bank;
            n_sh_valid = 1'b1;
            n_cnt      = '0;
        end else if (w_out_fire) begin
            for (int k = 0; k < GROUP_PIXELS - 1; k++) begin
                n_sh[k] = r_sh[k+1];
            end
            n_sh[GROUP_PIXELS-1] = '0;
            n_cnt = r_cnt + CNT_W'(1);
            if (w_last) begin
                n_sh_valid = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_full <= 1'b0;
            r_sh_valid  <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_bank_full <= n_bank_full;
            r_sh_valid  <= n_sh_valid;
            r_cnt       <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bank <= n_bank;
        r_sh   <= n_sh;
    end

    assign o_valid      = r_sh_valid;
    assign o_pixel_argb = r_sh[0];
    assign o_last_pixel = w_last;

endmodule

// ===== rtl/core/planar4_group_to_argb_pixels.sv =====
// top level: four-plane 16-pixel group to argb pixel stream
//
// input channel: i_valid/o_ready with four 16-bit plane words, one item is a
// group of 16 pixels, bit 15 of each word the leftmost pixel.
// output channel: o_valid/i_ready with one 32-bit argb pixel per item and
// o_last_pixel high on the sixteenth pixel of a group.
// palette: four 48-bit registers on the apb port at byte addresses 0, 8, 16
// and 24; the user must write them only while no group is in flight (the
// block does not enforce this). sixteen lanes look up all pixels of a group
// in the cycle it is accepted and park them in a group bank; the serialiser
// then sends them out. path: an accepted group is registered in the bank and
// moves to the shifter once that is free; its first pixel is the output.
// throughput: one pixel per cycle while i_ready is high, set by the single
// output port of the serialiser; one group can wait in the bank while
// another is being sent.
// reset: bank and serialiser empty, palette all zero, no pixel valid.
// stall: while i_ready is low the current pixel holds; once the bank is also
// full o_ready drops until the group in the serialiser has gone out.
module planar4_group_to_argb_pixels
    import p4argb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PLANE_W-1:0]    i_plane0_word,
    input  logic [PLANE_W-1:0]    i_plane1_word,
    input  logic [PLANE_W-1:0]    i_plane2_word,
    input  logic [PLANE_W-1:0]    i_plane3_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [31:0]           o_pixel_argb,
    output logic                  o_last_pixel
);

    t_palette w_palette;
    t_pix_arr w_lanes;

    // palette registers
    p4argb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_palette (w_palette)
    );

    // one lane per pixel, lane 0 is the leftmost pixel
    for (genvar k = 0; k < GROUP_PIXELS; k++) begin : g_lane
        localparam int BIT = PLANE_W - 1 - k;
        p4argb_lane u_lane (
            .i_index   ({i_plane3_word[BIT], i_plane2_word[BIT],
                         i_plane1_word[BIT], i_plane0_word[BIT]}),
            .i_palette (w_palette),
            .o_argb    (w_lanes[k])
        );
    end

    // bank and serialiser
    p4argb_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_lanes      (w_lanes),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_argb (o_pixel_argb),
        .o_last_pixel (o_last_pixel)
    );

endmodule

// ===== rtl/core/p4argb_checker.sv =====
// port-level checks for the converter and their binding
module p4argb_checker
    import p4argb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_pixel_argb,
    input logic        o_last_pixel
);

    localparam int CNT_W = $clog2(GROUP_PIXELS);

    logic [CNT_W-1:0] r_seen;

    // pixels delivered within the current group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (o_valid && i_ready) begin
            r_seen <= r_seen + CNT_W'(1);
        end
    end

    // last flag only on the sixteenth pixel of each group
    a_last_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_pixel == (r_seen == CNT_W'(GROUP_PIXELS - 1))))
        else $error("last pixel flag out of step with group");

    // every pixel is opaque
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pixel_argb[31:24] == ALPHA_OPAQUE)
        else $error("pixel alpha not opaque");

    // no pixel straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pixel valid after reset");

    // stalled pixel holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_argb)
                                && $stable(o_last_pixel))
        else $error("stalled pixel changed");

endmodule

bind planar4_group_to_argb_pixels p4argb_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_pixel_argb (o_pixel_argb),
    .o_last_pixel (o_last_pixel)
);

// ===== tb/sv/tb_planar4_group_to_argb_pixels.sv =====
// testbench for the four-plane group to argb pixel converter
module tb_planar4_group_to_argb_pixels;
    import p4argb_pkg::*;

    // cycles the receiver holds off in the back-pressure test
    localparam int HOLD_CYCLES = 300;
    // slowest run is about 350 groups x 16 pixels at heavy receiver idling,
    // plus the hold-off and palette writes; the limit is several times that
    localparam int CYCLE_LIMIT = 400000;
    // cycles to let pass after the last pixel before touching the palette
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [31:0] argb;
        logic        last;
    } t_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PLANE_W-1:0]    i_plane0_word = '0;
    logic [PLANE_W-1:0]    i_plane1_word = '0;
    logic [PLANE_W-1:0]    i_plane2_word = '0;
    logic [PLANE_W-1:0]    i_plane3_word = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [31:0]           o_pixel_argb;
    logic                  o_last_pixel;

    // palette copy kept in step with the register writes
    logic [REG_W-1:0] pal_shadow [PAL_REGS];
    // pixels still owed by the block, oldest first
    t_pixel           pending_pixels [$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_tag = 0;
    int hold_seen = 0;
    int hold_left = 0;

    planar4_group_to_argb_pixels u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_plane0_word (i_plane0_word),
        .i_plane1_word (i_plane1_word),
        .i_plane2_word (i_plane2_word),
        .i_plane3_word (i_plane3_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_argb  (o_pixel_argb),
        .o_last_pixel  (o_last_pixel)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_planar4_group_to_argb_pixels: done, errors");
            $finish;
        end
    end

    // receiver: random idling, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each pixel taken from the block with the oldest one owed
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel: expected none, got argb %h last %b",
                         $time, o_pixel_argb, o_last_pixel);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_argb !== want.argb) begin
                    $display("%0t: argb mismatch: expected %h, got %h",
                             $time, want.argb, o_pixel_argb);
                    error_count++;
                end
                if (o_last_pixel !== want.last) begin
                    $display("%0t: last mismatch: expected %b, got %b",
                             $time, want.last, o_last_pixel);
                    error_count++;
                end
            end
        end
    end

    // 3-bit channel stretched to a full byte
    function automatic logic [7:0] stretch_channel(input logic [2:0] v);
        logic [7:0] w;
        w = {5'b0, v};
        return (w << 5) | (w << 2) | (w >> 1);
    endfunction

    // colour of one palette index as opaque argb
    function automatic logic [31:0] pixel_colour(input logic [3:0] idx);
        logic [ENTRY_W-1:0] entry;
        entry = pal_shadow[idx[3:2]][ENTRY_W*idx[1:0] +: ENTRY_W];
        return {ALPHA_OPAQUE, stretch_channel(entry[10:8]),
                stretch_channel(entry[6:4]), stretch_channel(entry[2:0])};
    endfunction

    // queue the sixteen pixels a group turns into, leftmost first
    task automatic queue_group_pixels(input logic [PLANE_W-1:0] p0, p1, p2, p3);
        t_pixel     px;
        logic [3:0] idx;
        for (int k = 0; k < GROUP_PIXELS; k++) begin
            idx     = {p3[15-k], p2[15-k], p1[15-k], p0[15-k]};
            px.argb = pixel_colour(idx);
            px.last = (k == GROUP_PIXELS - 1);
            pending_pixels.push_back(px);
        end
    endtask

    // offer one group and wait until it is taken
    task automatic send_group(input logic [PLANE_W-1:0] p0, p1, p2, p3);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_plane0_word <= p0;
        i_plane1_word <= p1;
        i_plane2_word <= p2;
        i_plane3_word <= p3;
        do @(posedge i_clk); while (!o_ready);
        queue_group_pixels(p0, p1, p2, p3);
    endtask

    // stop offering and wait until every owed pixel has come out
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_palette(input t_reg_idx ridx, input logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pal_shadow[ridx] = value[REG_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // whole palette from sixteen entries; junk above bit 47 must be dropped
    task automatic load_palette(input t_palette pal);
        for (int r = 0; r < PAL_REGS; r++)
            write_palette(t_reg_idx'(r), {16'($urandom), pal[4*r +: 4]});
    endtask

    // plane word putting index k (or 15-k) at pixel k
    function automatic logic [PLANE_W-1:0] ramp_plane(input int j, input bit down);
        logic [PLANE_W-1:0] w;
        logic [3:0]         idx;
        for (int k = 0; k < GROUP_PIXELS; k++) begin
            idx       = down ? 4'(15 - k) : 4'(k);
            w[15 - k] = idx[j];
        end
        return w;
    endfunction

    function automatic logic [PLANE_W-1:0] rand_plane;
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return PLANE_W'(1) << $urandom_range(15);
            default: return PLANE_W'($urandom);
        endcase
    endfunction

    // palette straight after reset is all black
    task automatic test_reset_palette;
        send_group('1, '1, '1, '1);
        send_group(rand_plane(), rand_plane(), rand_plane(), rand_plane());
        drain();
    endtask

    // every index once, in both orders, with distinct entries, then all-0 and all-1 groups
    task automatic test_index_walk;
        t_palette pal;
        for (int n = 0; n < NUM_ENTRIES; n++)
            pal[n] = ENTRY_W'(n * 12'h2B5 + 12'h13);
        load_palette(pal);
        send_group(ramp_plane(0, 0), ramp_plane(1, 0), ramp_plane(2, 0), ramp_plane(3, 0));
        send_group(ramp_plane(0, 1), ramp_plane(1, 1), ramp_plane(2, 1), ramp_plane(3, 1));
        send_group('0, '0, '0, '0);
        send_group('1, '1, '1, '1);
        drain();
    endtask

    // each plane alone, alternating patterns and the edge pixels
    task automatic test_plane_bits;
        send_group('1, '0, '0, '0);
        send_group('0, '1, '0, '0);
        send_group('0, '0, '1, '0);
        send_group('0, '0, '0, '1);
        send_group(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_group(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_group(16'h8000, 16'h8000, 16'h0001, 16'h0001);
        send_group(16'h0001, 16'h8000, 16'h0001, 16'h8000);
        drain();
    endtask

    // top bit of each nibble must not reach the colour
    task automatic test_nibble_top_bit;
        t_palette pal;
        for (int n = 0; n < NUM_ENTRIES; n++) pal[n] = 12'h777;
        load_palette(pal);
        send_group(ramp_plane(0, 0), ramp_plane(1, 0), ramp_plane(2, 0), ramp_plane(3, 0));
        drain();
        for (int r = 0; r < PAL_REGS; r++) write_palette(t_reg_idx'(r), '1);
        send_group(ramp_plane(0, 1), ramp_plane(1, 1), ramp_plane(2, 1), ramp_plane(3, 1));
        send_group(rand_plane(), rand_plane(), rand_plane(), rand_plane());
        drain();
        for (int n = 0; n < NUM_ENTRIES; n++) pal[n] = 12'h888;
        load_palette(pal);
        send_group(ramp_plane(0, 0), ramp_plane(1, 0), ramp_plane(2, 0), ramp_plane(3, 0));
        drain();
    endtask

    // random groups in chunks, a fresh random palette for each chunk
    task automatic test_random_groups(input int s_pct, input int r_pct, input int chunks);
        t_palette pal;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int c = 0; c < chunks; c++) begin
            for (int n = 0; n < NUM_ENTRIES; n++) pal[n] = ENTRY_W'($urandom);
            load_palette(pal);
            for (int g = 0; g < 35; g++)
                send_group(rand_plane(), rand_plane(), rand_plane(), rand_plane());
            drain();
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_back_pressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge i_clk);
        hold_tag = hold_tag + 1;
        for (int g = 0; g < 10; g++)
            send_group(rand_plane(), rand_plane(), rand_plane(), rand_plane());
        drain();
    endtask

    // sequence of tests
    initial begin
        for (int r = 0; r < PAL_REGS; r++) pal_shadow[r] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_palette();
        test_index_walk();
        test_plane_bits();
        test_nibble_top_bit();
        test_random_groups(27, 87, 3);
        test_random_groups(87, 27, 3);
        test_random_groups(0, 0, 3);
        test_back_pressure();
        if (error_count == 0)
            $display("tb_planar4_group_to_argb_pixels: done, clean");
        else
            $display("tb_planar4_group_to_argb_pixels: done, errors");
        $finish;
    end

endmodule
